@@ sv/vhc_pkg.sv @@
`timescale 1ns / 1ps

package vhc_pkg;

  // mnemonic class codes on the input
  localparam logic [3:0] MN_OTHER = 4'd0;
  localparam logic [3:0] MN_PUSH  = 4'd1;
  localparam logic [3:0] MN_POP   = 4'd2;
  localparam logic [3:0] MN_ADD   = 4'd3;
  localparam logic [3:0] MN_SUB   = 4'd4;
  localparam logic [3:0] MN_XOR   = 4'd5;
  localparam logic [3:0] MN_AND   = 4'd6;
  localparam logic [3:0] MN_OR    = 4'd7;
  localparam logic [3:0] MN_SHR   = 4'd8;
  localparam logic [3:0] MN_SHL   = 4'd9;
  localparam logic [3:0] MN_CALL  = 4'd10;
  localparam logic [3:0] MN_CMP   = 4'd11;

  // handler class codes on the output
  localparam logic [3:0] HC_PUSH    = 4'd0;
  localparam logic [3:0] HC_POP     = 4'd1;
  localparam logic [3:0] HC_ADD     = 4'd2;
  localparam logic [3:0] HC_SUB     = 4'd3;
  localparam logic [3:0] HC_XOR     = 4'd4;
  localparam logic [3:0] HC_AND     = 4'd5;
  localparam logic [3:0] HC_OR      = 4'd6;
  localparam logic [3:0] HC_SHR     = 4'd7;
  localparam logic [3:0] HC_SHL     = 4'd8;
  localparam logic [3:0] HC_CMP_JCC = 4'd9;
  localparam logic [3:0] HC_CALL    = 4'd10;
  localparam logic [3:0] HC_LOAD    = 4'd11;
  localparam logic [3:0] HC_STORE   = 4'd12;
  localparam logic [3:0] HC_NOP     = 4'd13;
  localparam logic [3:0] HC_COMPLEX = 4'd14;

  localparam int          CNT_W         = 8;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;
  localparam logic [7:0]  NOP_MAX_INSNS = 8'd3;

  // sticky presence flags, push in bit 0
  typedef struct packed {
    logic mwr;
    logic mrd;
    logic jcc;
    logic cmp;
    logic call;
    logic shl;
    logic shr;
    logic bor;
    logic band;
    logic bxor;
    logic sub;
    logic add;
    logic pop;
    logic push;
  } flags_t;

endpackage

@@ sv/vhc_cascade.sv @@
`timescale 1ns / 1ps

module vhc_cascade (
  input  vhc_pkg::flags_t         flags,
  input  logic [vhc_pkg::CNT_W-1:0] count,
  output logic [3:0]              handler_class
);
  import vhc_pkg::*;

  logic any_alu;

  assign any_alu = flags.pop | flags.add | flags.sub | flags.bxor | flags.band | flags.bor;

  // first match wins
  always_comb begin
    if (flags.push && !any_alu) begin
      handler_class = HC_PUSH;
    end else if (flags.pop && !flags.push) begin
      handler_class = HC_POP;
    end else if (flags.add && !flags.sub) begin
      handler_class = HC_ADD;
    end else if (flags.sub) begin
      handler_class = HC_SUB;
    end else if (flags.bxor && !flags.band && !flags.bor) begin
      handler_class = HC_XOR;
    end else if (flags.band) begin
      handler_class = HC_AND;
    end else if (flags.bor) begin
      handler_class = HC_OR;
    end else if (flags.shr) begin
      handler_class = HC_SHR;
    end else if (flags.shl) begin
      handler_class = HC_SHL;
    end else if (flags.cmp && flags.jcc) begin
      handler_class = HC_CMP_JCC;
    end else if (flags.call) begin
      handler_class = HC_CALL;
    end else if (flags.mrd && !flags.mwr) begin
      handler_class = HC_LOAD;
    end else if (flags.mwr) begin
      handler_class = HC_STORE;
    end else if (count <= NOP_MAX_INSNS) begin
      handler_class = HC_NOP;
    end else begin
      handler_class = HC_COMPLEX;
    end
  end

endmodule

@@ sv/vm_handler_classifier.sv @@
`timescale 1ns / 1ps
// channel   | dir | tdata (low bit up)                                       | tlast
// s_axis    | in  | mnemonic_class[3:0] is_cond_branch[4] has_mem_read[5]   | last_insn
//           |     | has_mem_write[6] zero[7]                                 |
// m_axis    | out | handler_class[3:0] insn_count[11:4] zero[15:12]          | -
//
// one instruction request per cycle, except while a stalled result holds a last
// instruction back; an input register feeds the flag/count update, and the class
// of a handler is registered as its last instruction leaves the input register
// synchronous reset clears the valid bits, the sticky flags and the count
// a stalled result holds only the last instruction of the next handler back;
// other instructions keep flowing while the result waits

module vm_handler_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // mnemonic_class, is_cond_branch, has_mem_read, has_mem_write
  input  logic        s_axis_tlast,   // last_insn
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // handler_class, insn_count
);
  import vhc_pkg::*;

  // input register
  logic             in_valid;
  logic [3:0]       in_mnem;
  logic             in_jcc;
  logic             in_mrd;
  logic             in_mwr;
  logic             in_last;

  // accumulated state
  flags_t           seen_flags;
  logic [CNT_W-1:0] run_count;

  // result register
  logic [3:0]       out_class;
  logic [CNT_W-1:0] out_count;

  flags_t           hit;
  flags_t           seen_flags_next;
  logic [CNT_W-1:0] run_count_next;
  logic [3:0]       class_next;
  logic             stall;
  logic             move;
  logic             s_accept;

  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign move          = in_valid && !(in_last && stall);
  assign s_axis_tready = !in_valid || move;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hit = '0;
    case (in_mnem)
      MN_PUSH: hit.push = 1'b1;
      MN_POP:  hit.pop  = 1'b1;
      MN_ADD:  hit.add  = 1'b1;
      MN_SUB:  hit.sub  = 1'b1;
      MN_XOR:  hit.bxor = 1'b1;
      MN_AND:  hit.band = 1'b1;
      MN_OR:   hit.bor  = 1'b1;
      MN_SHR:  hit.shr  = 1'b1;
      MN_SHL:  hit.shl  = 1'b1;
      MN_CALL: hit.call = 1'b1;
      MN_CMP:  hit.cmp  = 1'b1;
      default: hit = '0;  // other and unused codes
    endcase
    hit.jcc = in_jcc;
    hit.mrd = in_mrd;
    hit.mwr = in_mwr;
  end

  assign seen_flags_next = seen_flags | hit;
  assign run_count_next  = (run_count == COUNT_MAX) ? run_count : run_count + CNT_W'(1);

  vhc_cascade u_cascade (
    .flags         (seen_flags_next),
    .count         (run_count_next),
    .handler_class (class_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      seen_flags    <= '0;
      run_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (move) begin
        if (in_last) begin
          seen_flags <= '0;
          run_count  <= '0;
        end else begin
          seen_flags <= seen_flags_next;
          run_count  <= run_count_next;
        end
      end
      if (move && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_mnem <= s_axis_tdata[3:0];
      in_jcc  <= s_axis_tdata[4];
      in_mrd  <= s_axis_tdata[5];
      in_mwr  <= s_axis_tdata[6];
      in_last <= s_axis_tlast;
    end
    if (move && in_last) begin
      out_class <= class_next;
      out_count <= run_count_next;
    end
  end

  assign m_axis_tdata = {4'b0000, out_count, out_class};

endmodule

@@ sv/vhc_checker.sv @@
`timescale 1ns / 1ps

module vhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import vhc_pkg::*;

  // a result never appears right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a held result keeps its value
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[11:4] != 8'd0)
    else $error("result with zero instruction count");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd15 && m_axis_tdata[15:12] == 4'd0)
    else $error("bad handler class or pad bits");

  // nop only for short handlers
  a_nop_short: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3:0] == HC_NOP |-> m_axis_tdata[11:4] <= NOP_MAX_INSNS)
    else $error("nop class on a long handler");

endmodule

bind vm_handler_classifier vhc_checker u_vhc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
